[src/sbpa_pkg.sv]
// ----------------------------------------------------------------------------
// sbpa_pkg
// Shared types, codes and constants of the size class block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpa_pkg;

  localparam int POOLS_DEF      = 4;
  localparam int MAX_BLOCKS_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int BYTES_W = 16;
  localparam int POOL_W  = 2;
  localparam int BLK_W   = 6;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_POOLS   = 4;
  localparam int CFG_BYTES0  = 0;
  localparam int CFG_TOTAL0  = 4;
  localparam int CFG_REGS    = 8;
  localparam int RESET_BYTES = 32;
  localparam int RESET_TOTAL = 64;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_QUERY,
    OP_DENY,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POOL_W-1:0] pool;
    logic [BLK_W-1:0]  block;
  } item_t;

  function automatic logic [BYTES_W-1:0] reset_bytes(input int p);
    logic [BYTES_W-1:0] v;
    v = '0;
    if (p < CFG_POOLS) begin
      v = BYTES_W'(RESET_BYTES << p);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[src/size_class_block_pool_allocator_unit.sv]
// ----------------------------------------------------------------------------
// size_class_block_pool_allocator_unit
// Segregated fixed-size block pool allocator with LIFO free stacks.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start while busy is low: allocate by size, free a
//   handle (pool, block) or query a pool's used and peak counters.
//   Every command gives one result, shown for one cycle with done high.
// Result path: an accepted command is written into the queue; the back end
//   then registers the result and the stack RAM read, and raises done.
// Throughput: one command per cycle; the back end updates a pool's fill,
//   used and peak counters and the stack RAM port in the same cycle, so
//   back-to-back commands on one pool see each other.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
//   (block sizes at 0..3, block totals at 4..7) and restarts all pools in the
//   cycle after; write only while no command is outstanding.
// Reset: sizes 32/64/128/256, totals 64, all stacks full; the pools are
//   ready in the cycle after rst falls, no memory clearing pass is needed since
//   unwritten stack slots are tracked by a per-pool low-water mark.
// The receiver cannot stall: results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_pool_allocator_unit #(
  parameter int POOLS      = sbpa_pkg::POOLS_DEF,
  parameter int MAX_BLOCKS = sbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [sbpa_pkg::CMD_W-1:0]      cmd,
  input  wire logic [sbpa_pkg::BYTES_W-1:0]    request_bytes,
  input  wire logic [sbpa_pkg::POOL_W-1:0]     handle_pool,
  input  wire logic [sbpa_pkg::BLK_W-1:0]      handle_block,
  output logic                                 done,
  output logic      [sbpa_pkg::STAT_W-1:0]     status,
  output logic      [sbpa_pkg::POOL_W-1:0]     granted_pool,
  output logic      [sbpa_pkg::BLK_W-1:0]      granted_block,
  output logic      [sbpa_pkg::CNT_W-1:0]      used_blocks,
  output logic      [sbpa_pkg::CNT_W-1:0]      peak_used_blocks
);

  localparam int IW = $bits(sbpa_pkg::item_t);
  localparam int QW = IW + POOLS;

  logic                         accept;
  sbpa_pkg::item_t              item;
  logic [POOLS-1:0]             fit;
  logic [sbpa_pkg::CNT_W-1:0]   total [POOLS];
  logic                         restart;
  logic                         head_valid;
  logic [QW-1:0]                head_data;
  sbpa_pkg::item_t              head_item;
  logic [POOLS-1:0]             head_fit;

  assign accept = start && !busy;

  sbpa_front #(
    .POOLS      (POOLS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .cmd           (cmd),
    .request_bytes (request_bytes),
    .handle_pool   (handle_pool),
    .handle_block  (handle_block),
    .item          (item),
    .fit           (fit),
    .total         (total),
    .restart       (restart)
  );

  sbpa_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  ({item, fit}),
    .pop        (head_valid),
    .head_valid (head_valid),
    .head_data  (head_data),
    .full       (busy)
  );

  assign head_item = sbpa_pkg::item_t'(head_data[QW-1:POOLS]);
  assign head_fit  = head_data[POOLS-1:0];

  sbpa_back #(
    .POOLS      (POOLS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .restart          (restart),
    .total            (total),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .head_fit         (head_fit),
    .done             (done),
    .status           (status),
    .granted_pool     (granted_pool),
    .granted_block    (granted_block),
    .used_blocks      (used_blocks),
    .peak_used_blocks (peak_used_blocks)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("result missing two cycles after accept");

  a_head_done: assert property (@(posedge clk) disable iff (rst)
    head_valid |=> done)
    else $error("queued item gave no result");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    (done && (status == sbpa_pkg::ST_OK)) |-> (used_blocks <= peak_used_blocks))
    else $error("used count above high-water mark");
`endif

endmodule

`default_nettype wire

[src/sbpa_ram.sv]
// ----------------------------------------------------------------------------
// sbpa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[src/sbpa_front.sv]
// ----------------------------------------------------------------------------
// sbpa_front
// Configuration registers, command intake and size class matching.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpa_front #(
  parameter int POOLS      = sbpa_pkg::POOLS_DEF,
  parameter int MAX_BLOCKS = sbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [sbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                accept,
  input  wire logic [sbpa_pkg::CMD_W-1:0]          cmd,
  input  wire logic [sbpa_pkg::BYTES_W-1:0]        request_bytes,
  input  wire logic [sbpa_pkg::POOL_W-1:0]         handle_pool,
  input  wire logic [sbpa_pkg::BLK_W-1:0]          handle_block,
  output sbpa_pkg::item_t                          item,
  output logic      [POOLS-1:0]                    fit,
  output logic      [sbpa_pkg::CNT_W-1:0]          total [POOLS],
  output logic                                     restart
);

  localparam int CW = sbpa_pkg::CNT_W;
  localparam int IW = sbpa_pkg::CFG_IDX_W;

  logic [sbpa_pkg::BYTES_W-1:0] bytes [POOLS];

  function automatic logic [CW-1:0] clamp_total(input logic [CW-1:0] v);
    return (v > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
      for (int p = 0; p < POOLS; p++) begin
        bytes[p] <= sbpa_pkg::reset_bytes(p);
        total[p] <= (p < sbpa_pkg::CFG_POOLS) ? clamp_total(CW'(sbpa_pkg::RESET_TOTAL))
                                              : '0;
      end
    end else begin
      restart <= cfg_write && (cfg_index < IW'(sbpa_pkg::CFG_REGS));
      if (cfg_write) begin
        for (int p = 0; p < POOLS; p++) begin
          if ((p < sbpa_pkg::CFG_POOLS) && (cfg_index == IW'(sbpa_pkg::CFG_BYTES0 + p))) begin
            bytes[p] <= cfg_data;
          end
          if ((p < sbpa_pkg::CFG_POOLS) && (cfg_index == IW'(sbpa_pkg::CFG_TOTAL0 + p))) begin
            total[p] <= clamp_total(cfg_data[CW-1:0]);
          end
        end
      end
    end
  end

  // size class match per pool
  always_comb begin
    for (int p = 0; p < POOLS; p++) begin
      fit[p] = accept && (bytes[p] >= request_bytes);
    end
  end

  always_comb begin
    item.pool  = handle_pool;
    item.block = handle_block;
    case (cmd)
      sbpa_pkg::CMD_ALLOC: begin
        item.op = sbpa_pkg::OP_ALLOC;
      end
      sbpa_pkg::CMD_FREE: begin
        item.op = (handle_pool < POOLS) ? sbpa_pkg::OP_FREE : sbpa_pkg::OP_REJECT;
      end
      sbpa_pkg::CMD_QUERY: begin
        item.op = (handle_pool < POOLS) ? sbpa_pkg::OP_QUERY : sbpa_pkg::OP_DENY;
      end
      default: begin
        item.op   = sbpa_pkg::OP_DENY;
        item.pool = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/sbpa_queue.sv]
// ----------------------------------------------------------------------------
// sbpa_queue
// Two-entry queue between the command front and the pool back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpa_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic      [WIDTH-1:0] head_data,
  output logic                  full
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[src/sbpa_back.sv]
// ----------------------------------------------------------------------------
// sbpa_back
// Pool back end: free stacks, fill, used and peak counters, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpa_back #(
  parameter int POOLS      = sbpa_pkg::POOLS_DEF,
  parameter int MAX_BLOCKS = sbpa_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           restart,
  input  wire logic [sbpa_pkg::CNT_W-1:0]     total [POOLS],
  input  wire logic                           head_valid,
  input  wire sbpa_pkg::item_t                head_item,
  input  wire logic [POOLS-1:0]               head_fit,
  output logic                                done,
  output logic      [sbpa_pkg::STAT_W-1:0]    status,
  output logic      [sbpa_pkg::POOL_W-1:0]    granted_pool,
  output logic      [sbpa_pkg::BLK_W-1:0]     granted_block,
  output logic      [sbpa_pkg::CNT_W-1:0]     used_blocks,
  output logic      [sbpa_pkg::CNT_W-1:0]     peak_used_blocks
);

  localparam int CW    = sbpa_pkg::CNT_W;
  localparam int BW    = sbpa_pkg::BLK_W;
  localparam int OPW   = sbpa_pkg::POOL_W;
  localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int AW    = $clog2(MAX_BLOCKS);
  localparam int DEPTH = (1 << PW) * (1 << AW);

  logic [CW-1:0] fill [POOLS];
  logic [CW-1:0] used [POOLS];
  logic [CW-1:0] peak [POOLS];
  logic [CW-1:0] low  [POOLS];

  logic              found;
  logic [PW-1:0]     psel;
  logic [PW-1:0]     pi;
  logic [CW-1:0]     cur_fill;
  logic [CW-1:0]     cur_used;
  logic [CW-1:0]     cur_peak;
  logic [CW-1:0]     cur_low;
  logic [CW-1:0]     cur_total;
  logic [CW-1:0]     pos;
  logic              upd;
  logic [CW-1:0]     fill_next;
  logic [CW-1:0]     used_next;
  logic [CW-1:0]     peak_next;
  logic [CW-1:0]     low_next;
  logic              ram_we;
  logic [PW+AW-1:0]  ram_addr;
  logic [BW-1:0]     ram_rdata;
  logic [sbpa_pkg::STAT_W-1:0] st_next;
  logic [OPW-1:0]    pool_next;
  logic [BW-1:0]     blk_next;
  logic              from_ram_next;

  logic [sbpa_pkg::STAT_W-1:0] st;
  logic [OPW-1:0]    pool;
  logic [BW-1:0]     blk;
  logic              from_ram;
  logic [CW-1:0]     used_out;
  logic [CW-1:0]     peak_out;

  // first pool in order that fits and has a free block
  always_comb begin
    found = 1'b0;
    psel  = '0;
    for (int p = POOLS - 1; p >= 0; p--) begin
      if (head_fit[p] && (fill[p] != '0)) begin
        found = 1'b1;
        psel  = PW'(p);
      end
    end
  end

  assign pi        = (head_item.op == sbpa_pkg::OP_ALLOC) ? psel : PW'(head_item.pool);
  assign cur_fill  = fill[pi];
  assign cur_used  = used[pi];
  assign cur_peak  = peak[pi];
  assign cur_low   = low[pi];
  assign cur_total = total[pi];
  assign pos       = cur_fill - CW'(1);

  always_comb begin
    upd           = 1'b0;
    fill_next     = cur_fill;
    used_next     = cur_used;
    peak_next     = cur_peak;
    low_next      = cur_low;
    ram_we        = 1'b0;
    ram_addr      = {pi, AW'(cur_fill)};
    st_next       = sbpa_pkg::ST_OK;
    pool_next     = OPW'(pi);
    blk_next      = '0;
    from_ram_next = 1'b0;
    case (head_item.op)
      sbpa_pkg::OP_ALLOC: begin
        if (found) begin
          upd           = 1'b1;
          fill_next     = pos;
          low_next      = (pos < cur_low) ? pos : cur_low;
          used_next     = (cur_used != '1) ? cur_used + CW'(1) : cur_used;
          peak_next     = (used_next > cur_peak) ? used_next : cur_peak;
          ram_addr      = {pi, AW'(pos)};
          // a slot never pushed since restart yields its own index as the block
          from_ram_next = (cur_low <= pos);
          blk_next      = BW'(pos);
        end else begin
          st_next   = sbpa_pkg::ST_NOFIT;
          pool_next = '0;
          used_next = '0;
          peak_next = '0;
        end
      end
      sbpa_pkg::OP_FREE: begin
        blk_next = head_item.block;
        if (cur_fill >= cur_total) begin
          st_next = sbpa_pkg::ST_REJECT;
        end else begin
          upd       = 1'b1;
          ram_we    = head_valid;
          fill_next = cur_fill + CW'(1);
          used_next = (cur_used != '0) ? cur_used - CW'(1) : cur_used;
        end
      end
      sbpa_pkg::OP_QUERY: begin
        st_next = sbpa_pkg::ST_OK;
      end
      sbpa_pkg::OP_REJECT: begin
        st_next   = sbpa_pkg::ST_REJECT;
        pool_next = head_item.pool;
        used_next = '0;
        peak_next = '0;
      end
      default: begin
        st_next   = sbpa_pkg::ST_NOFIT;
        pool_next = head_item.pool;
        used_next = '0;
        peak_next = '0;
      end
    endcase
  end

  sbpa_ram #(
    .WIDTH (BW),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (head_item.block),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < POOLS; p++) begin
        fill[p] <= '0;
        used[p] <= '0;
        peak[p] <= '0;
        low[p]  <= '0;
      end
    end else if (restart) begin
      for (int p = 0; p < POOLS; p++) begin
        fill[p] <= total[p];
        used[p] <= '0;
        peak[p] <= '0;
        low[p]  <= total[p];
      end
    end else if (head_valid && upd) begin
      fill[pi] <= fill_next;
      used[pi] <= used_next;
      peak[pi] <= peak_next;
      low[pi]  <= low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid) begin
      st       <= st_next;
      pool     <= pool_next;
      blk      <= blk_next;
      from_ram <= from_ram_next;
      used_out <= used_next;
      peak_out <= peak_next;
    end
  end

  assign status           = st;
  assign granted_pool     = pool;
  assign granted_block    = from_ram ? ram_rdata : blk;
  assign used_blocks      = used_out;
  assign peak_used_blocks = peak_out;

endmodule

`default_nettype wire
